### rtl/tone_sequence_channel_scheduler_assert.svh
// Assertion macros used by the checker file of the tone scheduler.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef TONE_SEQUENCE_CHANNEL_SCHEDULER_ASSERT_SVH
`define TONE_SEQUENCE_CHANNEL_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSSCHED_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tone scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSSCHED_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tone scheduler check failed");

`endif

### rtl/tssched_pkg.sv
`timescale 1ns / 1ps

package tssched_pkg;

   // Default sizes of the block.
   localparam int VOICES_DEF             = 18;
   localparam int FIRST_SHARED_VOICE_DEF = 3;
   localparam int SLOTS_DEF              = 16;
   localparam int TONES_PER_SEQ_DEF      = 32;

   // Request opcodes.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_COMMIT = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // Result action codes.
   localparam logic [2:0] ACT_NOTE_ON  = 3'd0;
   localparam logic [2:0] ACT_NOTE_OFF = 3'd1;
   localparam logic [2:0] ACT_QUEUED   = 3'd2;
   localparam logic [2:0] ACT_NO_VOICE = 3'd3;
   localparam logic [2:0] ACT_NO_SLOT  = 3'd4;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_COMMIT,
      S_COPY,
      S_TICK_CHECK,
      S_TICK_PLAY,
      S_CLEAR,
      S_FLUSH
   } state_type;

   // Datapath commands, one per cycle.
   typedef enum logic [3:0] {
      DP_NONE,
      DP_STAGE,
      DP_ACCEPT,
      DP_FAIL_VOICE,
      DP_FAIL_SLOT,
      DP_CLAIM,
      DP_COPY,
      DP_COPY_END,
      DP_TICK_SKIP,
      DP_TICK_READ,
      DP_TICK_PLAY,
      DP_TICK_RETIRE,
      DP_CLEAR_STEP,
      DP_FLUSH
   } dp_op_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic voice_found;
      logic slot_found;
      logic copy_done;
      logic voice_valid;
      logic due;
      logic has_tone;
      logic last_voice;
   } dp_status_type;

endpackage

### rtl/tssched_ram.sv
`timescale 1ns / 1ps

module tssched_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tssched_ctrl.sv
`timescale 1ns / 1ps

module tssched_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [1:0]                 req_opcode,
   input  tssched_pkg::dp_status_type status,
   output logic                       busy,
   output tssched_pkg::dp_op_type     dp_op
);

   tssched_pkg::state_type state_ff;
   tssched_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tssched_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath command.
   always_comb begin
      state_in = state_ff;
      dp_op    = tssched_pkg::DP_NONE;
      case (state_ff)
         tssched_pkg::S_IDLE: begin
            if (start) begin
               case (req_opcode)
                  tssched_pkg::OP_APPEND: begin
                     dp_op = tssched_pkg::DP_STAGE;
                  end
                  tssched_pkg::OP_COMMIT: begin
                     dp_op    = tssched_pkg::DP_ACCEPT;
                     state_in = tssched_pkg::S_COMMIT;
                  end
                  tssched_pkg::OP_TICK: begin
                     dp_op    = tssched_pkg::DP_ACCEPT;
                     state_in = tssched_pkg::S_TICK_CHECK;
                  end
                  default: begin
                     dp_op    = tssched_pkg::DP_ACCEPT;
                     state_in = tssched_pkg::S_CLEAR;
                  end
               endcase
            end
         end
         tssched_pkg::S_COMMIT: begin
            if (!status.voice_found) begin
               dp_op    = tssched_pkg::DP_FAIL_VOICE;
               state_in = tssched_pkg::S_FLUSH;
            end else if (!status.slot_found) begin
               dp_op    = tssched_pkg::DP_FAIL_SLOT;
               state_in = tssched_pkg::S_FLUSH;
            end else begin
               dp_op    = tssched_pkg::DP_CLAIM;
               state_in = tssched_pkg::S_COPY;
            end
         end
         tssched_pkg::S_COPY: begin
            if (status.copy_done) begin
               dp_op    = tssched_pkg::DP_COPY_END;
               state_in = tssched_pkg::S_FLUSH;
            end else begin
               dp_op = tssched_pkg::DP_COPY;
            end
         end
         tssched_pkg::S_TICK_CHECK: begin
            if (status.voice_valid && status.due && status.has_tone) begin
               dp_op    = tssched_pkg::DP_TICK_READ;
               state_in = tssched_pkg::S_TICK_PLAY;
            end else begin
               if (status.voice_valid && status.due) begin
                  dp_op = tssched_pkg::DP_TICK_RETIRE;
               end else begin
                  dp_op = tssched_pkg::DP_TICK_SKIP;
               end
               if (status.last_voice) begin
                  state_in = tssched_pkg::S_FLUSH;
               end
            end
         end
         tssched_pkg::S_TICK_PLAY: begin
            dp_op = tssched_pkg::DP_TICK_PLAY;
            if (status.last_voice) begin
               state_in = tssched_pkg::S_FLUSH;
            end else begin
               state_in = tssched_pkg::S_TICK_CHECK;
            end
         end
         tssched_pkg::S_CLEAR: begin
            dp_op = tssched_pkg::DP_CLEAR_STEP;
            if (status.last_voice) begin
               state_in = tssched_pkg::S_FLUSH;
            end
         end
         tssched_pkg::S_FLUSH: begin
            dp_op    = tssched_pkg::DP_FLUSH;
            state_in = tssched_pkg::S_IDLE;
         end
         default: begin
            state_in = tssched_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != tssched_pkg::S_IDLE);

endmodule

### rtl/tssched_datapath.sv
`timescale 1ns / 1ps

module tssched_datapath #(
   parameter int VOICES             = tssched_pkg::VOICES_DEF,
   parameter int FIRST_SHARED_VOICE = tssched_pkg::FIRST_SHARED_VOICE_DEF,
   parameter int SLOTS              = tssched_pkg::SLOTS_DEF,
   parameter int TONES_PER_SEQ      = tssched_pkg::TONES_PER_SEQ_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tssched_pkg::dp_op_type     dp_op,
   input  logic [15:0]                req_tone_freq,
   input  logic [15:0]                req_tone_duration,
   input  logic [31:0]                req_now_tick,
   output tssched_pkg::dp_status_type status,
   output logic                       rsp_strobe,
   output logic [2:0]                 rsp_action,
   output logic [4:0]                 rsp_voice,
   output logic [15:0]                rsp_out_freq,
   output logic [3:0]                 rsp_slot_used,
   output logic                       rsp_last_of_run
);

   localparam int VW   = $clog2(VOICES);
   localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW   = $clog2(TONES_PER_SEQ + 1);
   localparam int SAW  = (TONES_PER_SEQ > 1) ? $clog2(TONES_PER_SEQ) : 1;
   localparam int TAW  = (SLOTS * TONES_PER_SEQ > 1) ? $clog2(SLOTS * TONES_PER_SEQ) : 1;

   // Request and sequencing registers.
   logic [31:0]   now_ff, now_in;
   logic [VW-1:0] v_ff, v_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic [PW-1:0] wr_idx_ff, wr_idx_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [SW-1:0] claim_slot_ff, claim_slot_in;
   logic [PW-1:0] staged_count_ff, staged_count_in;

   // Voice and slot state.
   logic [VOICES-1:0] voice_valid_ff, voice_valid_in;
   logic [SW-1:0]     voice_slot_ff [VOICES];
   logic [SW-1:0]     voice_slot_in [VOICES];
   logic [SLOTS-1:0]  slot_busy_ff, slot_busy_in;
   logic [31:0]       slot_deadline_ff [SLOTS];
   logic [31:0]       slot_deadline_in [SLOTS];
   logic [PW-1:0]     slot_length_ff [SLOTS];
   logic [PW-1:0]     slot_length_in [SLOTS];
   logic [PW-1:0]     slot_position_ff [SLOTS];
   logic [PW-1:0]     slot_position_in [SLOTS];

   // Pending result, held back until it is known whether it is the last one.
   logic        pend_valid_ff, pend_valid_in;
   logic [2:0]  pend_action_ff, pend_action_in;
   logic [4:0]  pend_voice_ff, pend_voice_in;
   logic [15:0] pend_freq_ff, pend_freq_in;
   logic [3:0]  pend_slot_ff, pend_slot_in;

   // Result port registers.
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]  rsp_action_ff, rsp_action_in;
   logic [4:0]  rsp_voice_ff, rsp_voice_in;
   logic [15:0] rsp_freq_ff, rsp_freq_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic           stg_we;
   logic [31:0]    stg_rdata;
   logic [TAW-1:0] tone_waddr;
   logic [TAW-1:0] tone_raddr;
   logic [31:0]    tone_rdata;

   // Combinational helpers.
   logic          voice_found;
   logic [VW-1:0] free_voice;
   logic          slot_found;
   logic [SW-1:0] free_slot;
   logic [SW-1:0] cur_s;
   logic          emit_valid;
   logic [2:0]    emit_action;
   logic [4:0]    emit_voice;
   logic [15:0]   emit_freq;
   logic [3:0]    emit_slot;

   // Staging buffer and tone store.
   tssched_ram #(.WIDTH(32), .DEPTH(TONES_PER_SEQ)) u_stage_ram (
      .clock   (clock),
      .wr_en   (stg_we),
      .wr_addr (SAW'(staged_count_ff)),
      .wr_data ({req_tone_freq, req_tone_duration}),
      .rd_addr (SAW'(idx_ff)),
      .rd_data (stg_rdata)
   );

   tssched_ram #(.WIDTH(32), .DEPTH(SLOTS * TONES_PER_SEQ)) u_tone_ram (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (tone_waddr),
      .wr_data (stg_rdata),
      .rd_addr (tone_raddr),
      .rd_data (tone_rdata)
   );

   assign cur_s      = voice_slot_ff[v_ff];
   assign tone_waddr = TAW'(claim_slot_ff) * TAW'(TONES_PER_SEQ) + TAW'(wr_idx_ff);
   assign tone_raddr = TAW'(cur_s) * TAW'(TONES_PER_SEQ) + TAW'(slot_position_ff[cur_s]);

   // Lowest free shared voice and lowest idle slot.
   always_comb begin
      voice_found = 1'b0;
      free_voice  = '0;
      for (int i = VOICES - 1; i >= FIRST_SHARED_VOICE; i--) begin
         if (!voice_valid_ff[i]) begin
            voice_found = 1'b1;
            free_voice  = VW'(i);
         end
      end
      slot_found = 1'b0;
      free_slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_busy_ff[i]) begin
            slot_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   // Status towards the controller.
   always_comb begin
      status.voice_found = voice_found;
      status.slot_found  = slot_found;
      status.copy_done   = (idx_ff >= staged_count_ff) && !wr_pend_ff;
      status.voice_valid = voice_valid_ff[v_ff];
      status.due         = (slot_deadline_ff[cur_s] <= now_ff);
      status.has_tone    = (slot_position_ff[cur_s] < slot_length_ff[cur_s]);
      status.last_voice  = (v_ff == VW'(VOICES - 1));
   end

   // Next state of the datapath for the current command.
   always_comb begin
      now_in           = now_ff;
      v_in             = v_ff;
      idx_in           = idx_ff;
      wr_idx_in        = wr_idx_ff;
      wr_pend_in       = 1'b0;
      claim_slot_in    = claim_slot_ff;
      staged_count_in  = staged_count_ff;
      voice_valid_in   = voice_valid_ff;
      voice_slot_in    = voice_slot_ff;
      slot_busy_in     = slot_busy_ff;
      slot_deadline_in = slot_deadline_ff;
      slot_length_in   = slot_length_ff;
      slot_position_in = slot_position_ff;
      pend_valid_in    = pend_valid_ff;
      pend_action_in   = pend_action_ff;
      pend_voice_in    = pend_voice_ff;
      pend_freq_in     = pend_freq_ff;
      pend_slot_in     = pend_slot_ff;
      rsp_strobe_in    = 1'b0;
      rsp_action_in    = rsp_action_ff;
      rsp_voice_in     = rsp_voice_ff;
      rsp_freq_in      = rsp_freq_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_last_in      = rsp_last_ff;
      stg_we           = 1'b0;
      emit_valid       = 1'b0;
      emit_action      = tssched_pkg::ACT_NOTE_OFF;
      emit_voice       = 5'(v_ff);
      emit_freq        = '0;
      emit_slot        = '0;
      case (dp_op)
         tssched_pkg::DP_STAGE: begin
            if (staged_count_ff < PW'(TONES_PER_SEQ)) begin
               stg_we          = 1'b1;
               staged_count_in = staged_count_ff + 1'b1;
            end
         end
         tssched_pkg::DP_ACCEPT: begin
            now_in = req_now_tick;
            v_in   = '0;
            idx_in = '0;
         end
         tssched_pkg::DP_FAIL_VOICE: begin
            emit_valid      = 1'b1;
            emit_action     = tssched_pkg::ACT_NO_VOICE;
            emit_voice      = '0;
            staged_count_in = '0;
         end
         tssched_pkg::DP_FAIL_SLOT: begin
            emit_valid      = 1'b1;
            emit_action     = tssched_pkg::ACT_NO_SLOT;
            emit_voice      = '0;
            staged_count_in = '0;
         end
         tssched_pkg::DP_CLAIM: begin
            slot_busy_in[free_slot]     = 1'b1;
            slot_deadline_in[free_slot] = now_ff;
            slot_length_in[free_slot]   = staged_count_ff;
            slot_position_in[free_slot] = '0;
            voice_valid_in[free_voice]  = 1'b1;
            voice_slot_in[free_voice]   = free_slot;
            claim_slot_in               = free_slot;
            emit_valid                  = 1'b1;
            emit_action                 = tssched_pkg::ACT_QUEUED;
            emit_voice                  = 5'(free_voice);
            emit_slot                   = 4'(free_slot);
         end
         tssched_pkg::DP_COPY: begin
            // Read one staged tone a cycle; it is written to the tone memory in the following cycle.
            if (idx_ff < staged_count_ff) begin
               wr_pend_in = 1'b1;
               wr_idx_in  = idx_ff;
               idx_in     = idx_ff + 1'b1;
            end
         end
         tssched_pkg::DP_COPY_END: begin
            staged_count_in = '0;
         end
         tssched_pkg::DP_TICK_SKIP: begin
            v_in = v_ff + 1'b1;
         end
         tssched_pkg::DP_TICK_PLAY: begin
            emit_valid = 1'b1;
            if (tone_rdata[31:16] != 16'd0) begin
               emit_action = tssched_pkg::ACT_NOTE_ON;
               emit_freq   = tone_rdata[31:16];
            end
            slot_deadline_in[cur_s] = now_ff + 32'(tone_rdata[15:0]);
            slot_position_in[cur_s] = slot_position_ff[cur_s] + 1'b1;
            v_in                    = v_ff + 1'b1;
         end
         tssched_pkg::DP_TICK_RETIRE: begin
            emit_valid           = 1'b1;
            voice_valid_in[v_ff] = 1'b0;
            slot_busy_in[cur_s]  = 1'b0;
            v_in                 = v_ff + 1'b1;
         end
         tssched_pkg::DP_CLEAR_STEP: begin
            emit_valid     = 1'b1;
            voice_valid_in = '0;
            slot_busy_in   = '0;
            v_in           = v_ff + 1'b1;
         end
         tssched_pkg::DP_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_action_in = pend_action_ff;
               rsp_voice_in  = pend_voice_ff;
               rsp_freq_in   = pend_freq_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_last_in   = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         default: begin
         end
      endcase

      // A new result pushes the held one out as a beat that is not the last.
      if (emit_valid) begin
         if (pend_valid_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_action_in = pend_action_ff;
            rsp_voice_in  = pend_voice_ff;
            rsp_freq_in   = pend_freq_ff;
            rsp_slot_in   = pend_slot_ff;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_action_in = emit_action;
         pend_voice_in  = emit_voice;
         pend_freq_in   = emit_freq;
         pend_slot_in   = emit_slot;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff      <= 1'b0;
         staged_count_ff <= '0;
         voice_valid_ff  <= '0;
         slot_busy_ff    <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         wr_pend_ff      <= wr_pend_in;
         staged_count_ff <= staged_count_in;
         voice_valid_ff  <= voice_valid_in;
         slot_busy_ff    <= slot_busy_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      now_ff           <= now_in;
      v_ff             <= v_in;
      idx_ff           <= idx_in;
      wr_idx_ff        <= wr_idx_in;
      claim_slot_ff    <= claim_slot_in;
      voice_slot_ff    <= voice_slot_in;
      slot_deadline_ff <= slot_deadline_in;
      slot_length_ff   <= slot_length_in;
      slot_position_ff <= slot_position_in;
      pend_action_ff   <= pend_action_in;
      pend_voice_ff    <= pend_voice_in;
      pend_freq_ff     <= pend_freq_in;
      pend_slot_ff     <= pend_slot_in;
      rsp_action_ff    <= rsp_action_in;
      rsp_voice_ff     <= rsp_voice_in;
      rsp_freq_ff      <= rsp_freq_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_voice       = rsp_voice_ff;
   assign rsp_out_freq    = rsp_freq_ff;
   assign rsp_slot_used   = rsp_slot_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

### rtl/tone_sequence_channel_scheduler.sv
`timescale 1ns / 1ps
// Tone sequence scheduler for a bank of synthesizer voices.
// Requests: raise start with req_opcode and its fields; the request is taken at
// a clock edge where start is high and busy is low. Append does not raise busy
// and gives no result. Commit, tick and clear raise busy until their results are out.
// Results: each beat is on the rsp_ ports for one cycle with rsp_strobe high;
// rsp_last_of_run marks the final beat of a request. The receiver cannot stall.
// Sequencing: a failed commit goes straight to the result flush; otherwise a
// commit claims a shared voice and a slot, then copies the staged tones through
// the staging and tone memories. A tick walks the voices in order, with an extra
// state for each voice that plays a tone (the tone memory read). A clear walks
// all voices. The last beat appears in the first cycle with busy low, and a new
// request may already be taken in that same cycle.
// Reset frees all voices and slots and empties the staging buffer; the tone
// memory needs no clearing since every entry is written before it is read.
module tone_sequence_channel_scheduler #(
   parameter int VOICES             = tssched_pkg::VOICES_DEF,
   parameter int FIRST_SHARED_VOICE = tssched_pkg::FIRST_SHARED_VOICE_DEF,
   parameter int SLOTS              = tssched_pkg::SLOTS_DEF,
   parameter int TONES_PER_SEQ      = tssched_pkg::TONES_PER_SEQ_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_tone_freq,
   input  logic [15:0] req_tone_duration,
   input  logic [31:0] req_now_tick,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_action,
   output logic [4:0]  rsp_voice,
   output logic [15:0] rsp_out_freq,
   output logic [3:0]  rsp_slot_used,
   output logic        rsp_last_of_run
);

   tssched_pkg::dp_op_type     dp_op;
   tssched_pkg::dp_status_type status;

   // Sequencing of each request.
   tssched_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .busy       (busy),
      .dp_op      (dp_op)
   );

   // Voice, slot and tone storage.
   tssched_datapath #(
      .VOICES             (VOICES),
      .FIRST_SHARED_VOICE (FIRST_SHARED_VOICE),
      .SLOTS              (SLOTS),
      .TONES_PER_SEQ      (TONES_PER_SEQ)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_op             (dp_op),
      .req_tone_freq     (req_tone_freq),
      .req_tone_duration (req_tone_duration),
      .req_now_tick      (req_now_tick),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_action        (rsp_action),
      .rsp_voice         (rsp_voice),
      .rsp_out_freq      (rsp_out_freq),
      .rsp_slot_used     (rsp_slot_used),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

### rtl/tssched_checker.sv
`timescale 1ns / 1ps
`include "tone_sequence_channel_scheduler_assert.svh"

module tssched_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_opcode,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_action,
   input logic [15:0] rsp_out_freq,
   input logic        rsp_last_of_run
);

   logic take_append;
   logic take_work;
   logic status_beat;
   logic plain_beat;

   // Requests taken this cycle, split by whether they give results.
   assign take_append = start && !busy && (req_opcode == tssched_pkg::OP_APPEND);
   assign take_work   = start && !busy && (req_opcode != tssched_pkg::OP_APPEND);

   // Beats that report the outcome of a commit, and beats that are not a note-on.
   assign status_beat = rsp_strobe && (rsp_action inside {tssched_pkg::ACT_QUEUED,
                        tssched_pkg::ACT_NO_VOICE, tssched_pkg::ACT_NO_SLOT});
   assign plain_beat  = rsp_strobe && (rsp_action != tssched_pkg::ACT_NOTE_ON);

   // An append gives no beat.
   `TSSCHED_ASSERT_NEXT(a_append_silent, take_append, !rsp_strobe)

   // Commit, tick and clear raise busy in the cycle after they are taken.
   `TSSCHED_ASSERT_NEXT(a_work_busy, take_work, busy)

   // A commit answers with a single beat, so its status is always the last.
   `TSSCHED_ASSERT_SAME(a_commit_last, status_beat, rsp_last_of_run)

   // Only a note-on carries a frequency.
   `TSSCHED_ASSERT_SAME(a_freq_only_on, plain_beat, rsp_out_freq == 16'd0)

endmodule

bind tone_sequence_channel_scheduler tssched_checker u_checker (.*);
